FILE: rtl/bd3_pkg.sv
// ----------------------------------------------------------------------------
// bd3_pkg: shared types and constants of the 3x3 binary dilation engine
// Field widths, operation and register codes, window tap offsets and the
// control/status bundles between the top level and the scan sequencer.
// ----------------------------------------------------------------------------
package bd3_pkg;

   // default storage geometry
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // field widths
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 6;
   localparam int DIM_W      = 7;
   localparam int PASS_W     = 8;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int STEP_W     = 4;

   // request beat layout (tdata): x_pos, y_pos, pixel_in, zero fill
   localparam int REQ_DATA_W = 24;
   localparam int X_LSB      = 0;
   localparam int Y_LSB      = X_LSB + COORD_W;
   localparam int PIX_LSB    = Y_LSB + COORD_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_WHITE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   // configuration reset values
   localparam logic [PASS_W-1:0] RST_PASS_COUNT = 8'd1;
   localparam logic [DIM_W-1:0]  RST_FRAME_DIM  = 7'd64;

   // pixel colors
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

   // window walk: step 0 is the center, steps 1..8 the neighbors,
   // the final step evaluates and writes the pixel
   localparam logic [STEP_W-1:0] STEP_CENTER      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CENTER_DATA = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LAST        = 4'd9;

   // tap offset codes
   localparam logic [1:0] OFS_ZERO  = 2'b00;
   localparam logic [1:0] OFS_PLUS  = 2'b01;
   localparam logic [1:0] OFS_MINUS = 2'b11;

   typedef struct packed {
      logic              grow_white;
      logic [PASS_W-1:0] pass_count;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
   } run_cfg_type;

   typedef struct packed {
      logic        start;
      run_cfg_type cfg;
   } scan_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scan_stat_type;

   // column offset of a window step
   function automatic logic [1:0] win_dx(input logic [STEP_W-1:0] step);
      logic [1:0] ofs;
      ofs = OFS_ZERO;
      if (step inside {4'd1, 4'd4, 4'd6}) begin
         ofs = OFS_MINUS;
      end else if (step inside {4'd3, 4'd5, 4'd8}) begin
         ofs = OFS_PLUS;
      end
      return ofs;
   endfunction

   // row offset of a window step
   function automatic logic [1:0] win_dy(input logic [STEP_W-1:0] step);
      logic [1:0] ofs;
      ofs = OFS_ZERO;
      if (step inside {4'd1, 4'd2, 4'd3}) begin
         ofs = OFS_MINUS;
      end else if (step inside {4'd6, 4'd7, 4'd8}) begin
         ofs = OFS_PLUS;
      end
      return ofs;
   endfunction

endpackage

FILE: rtl/binary_dilation_3x3.sv
// ----------------------------------------------------------------------------
// binary_dilation_3x3: 3x3 binary dilation engine over a stored 8-bit frame
// A pixel write or an unused operation answers in the cycle after its request
// beat, a pixel read after its beat has passed the read state. A run makes
// pass_count passes over the frame in use; each pass fetches every window one
// tap per cycle through the single read port of the source memory, then
// writes the new pixel, copies the pass back to the source pixel by pixel and
// turns around in a flush state. No request is taken while a run or a read is
// in progress. Both frame memories come up holding anything; no pixel may be
// read, or covered by a run, before it is written.
// ----------------------------------------------------------------------------
module binary_dilation_3x3 #(
   parameter int MAX_WIDTH  = bd3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bd3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bd3_pkg::REQ_DATA_W-1:0]     req_tdata,  // x_pos, y_pos, pixel_in, zero fill
   input  logic [bd3_pkg::OP_W-1:0]           req_tuser,  // op
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bd3_pkg::PIX_W-1:0]          rsp_tdata,  // pixel_out
   output logic                               rsp_tuser,  // done_res
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bd3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bd3_pkg::CSR_DATA_W-1:0]     csr_data
);

   import bd3_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_RUN  = 2'd2;

   logic [1:0]        state_ff,     state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff,   rsp_pix_in;
   logic              rsp_done_ff,  rsp_done_in;
   logic              rd_ok_ff,     rd_ok_in;

   logic              grow_ff;
   logic [PASS_W-1:0] pass_cnt_ff;
   logic [DIM_W-1:0]  fw_ff;
   logic [DIM_W-1:0]  fh_ff;

   logic [COORD_W-1:0] x_pos;
   logic [COORD_W-1:0] y_pos;
   logic [PIX_W-1:0]   pixel_in;
   logic [OP_W-1:0]    op;
   logic               in_store;
   logic [AW-1:0]      acc_addr;
   logic               req_acc;
   logic               rsp_take;
   logic               host_wr;
   logic               scan_start;

   scan_ctrl_type      scan_ctrl;
   scan_stat_type      scan_stat;

   logic [AW-1:0]      src_rd_addr;
   logic [PIX_W-1:0]   src_rd_data;
   logic               src_wr_en;
   logic [AW-1:0]      src_wr_addr;
   logic [PIX_W-1:0]   src_wr_data;
   logic [AW-1:0]      scan_src_rd_addr;
   logic               scan_src_wr_en;
   logic [AW-1:0]      scan_src_wr_addr;
   logic [PIX_W-1:0]   scan_src_wr_data;
   logic               res_wr_en;
   logic [AW-1:0]      res_wr_addr;
   logic [PIX_W-1:0]   res_wr_data;
   logic [AW-1:0]      res_rd_addr;
   logic [PIX_W-1:0]   res_rd_data;

   // unpack the request beat
   assign op       = req_tuser;
   assign x_pos    = req_tdata[X_LSB +: COORD_W];
   assign y_pos    = req_tdata[Y_LSB +: COORD_W];
   assign pixel_in = req_tdata[PIX_LSB +: PIX_W];
   assign in_store = (32'(x_pos) < MAX_WIDTH) && (32'(y_pos) < MAX_HEIGHT);
   assign acc_addr = AW'(32'(y_pos) * MAX_WIDTH + 32'(x_pos));

   assign req_acc    = req_tvalid & req_tready;
   assign rsp_take   = rsp_valid_ff & rsp_tready;
   assign req_tready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_ff     <= 1'b0;
         pass_cnt_ff <= RST_PASS_COUNT;
         fw_ff       <= RST_FRAME_DIM;
         fh_ff       <= RST_FRAME_DIM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GROW_WHITE:   grow_ff     <= csr_data[0];
            CSR_PASS_COUNT:   pass_cnt_ff <= csr_data[PASS_W-1:0];
            CSR_FRAME_WIDTH:  fw_ff       <= csr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff       <= csr_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // saturate the frame in use to the storage size
   always_comb begin
      scan_ctrl.start              = scan_start;
      scan_ctrl.cfg.grow_white     = grow_ff;
      scan_ctrl.cfg.pass_count     = pass_cnt_ff;
      scan_ctrl.cfg.width          = fw_ff;
      scan_ctrl.cfg.height         = fh_ff;
      if (32'(fw_ff) > MAX_WIDTH) begin
         scan_ctrl.cfg.width = DIM_W'(MAX_WIDTH);
      end
      if (32'(fh_ff) > MAX_HEIGHT) begin
         scan_ctrl.cfg.height = DIM_W'(MAX_HEIGHT);
      end
   end

   // request decode and response slot
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_take;
      rsp_pix_in   = rsp_pix_ff;
      rsp_done_in  = rsp_done_ff;
      rd_ok_in     = rd_ok_ff;
      host_wr      = 1'b0;
      scan_start   = 1'b0;

      case (state_ff)
         T_IDLE: begin
            if (req_acc) begin
               case (op)
                  OP_WRITE: begin
                     host_wr      = in_store;
                     rsp_valid_in = 1'b1;
                     rsp_pix_in   = '0;
                     rsp_done_in  = 1'b1;
                  end
                  OP_RUN: begin
                     scan_start = 1'b1;
                     state_in   = T_RUN;
                  end
                  OP_READ: begin
                     rd_ok_in = in_store;
                     state_in = T_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_pix_in   = '0;
                     rsp_done_in  = 1'b0;
                  end
               endcase
            end
         end

         T_READ: begin
            rsp_valid_in = 1'b1;
            rsp_pix_in   = rd_ok_ff ? src_rd_data : '0;
            rsp_done_in  = 1'b1;
            state_in     = T_IDLE;
         end

         T_RUN: begin
            if (scan_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = '0;
               rsp_done_in  = 1'b1;
               state_in     = T_IDLE;
            end
         end

         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      rsp_done_ff <= rsp_done_in;
      rd_ok_ff    <= rd_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_done_ff;

   // source memory: host access while idle, sequencer otherwise
   assign src_wr_en   = host_wr | scan_src_wr_en;
   assign src_wr_addr = host_wr ? acc_addr : scan_src_wr_addr;
   assign src_wr_data = host_wr ? pixel_in : scan_src_wr_data;
   assign src_rd_addr = (state_ff == T_IDLE) ? acc_addr : scan_src_rd_addr;

   bd3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_wr_en),
      .wr_addr (src_wr_addr),
      .wr_data (src_wr_data),
      .rd_addr (src_rd_addr),
      .rd_data (src_rd_data)
   );

   bd3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_res_ram (
      .clock   (clock),
      .wr_en   (res_wr_en),
      .wr_addr (res_wr_addr),
      .wr_data (res_wr_data),
      .rd_addr (res_rd_addr),
      .rd_data (res_rd_data)
   );

   bd3_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .stat        (scan_stat),
      .src_rd_addr (scan_src_rd_addr),
      .src_rd_data (src_rd_data),
      .src_wr_en   (scan_src_wr_en),
      .src_wr_addr (scan_src_wr_addr),
      .src_wr_data (scan_src_wr_data),
      .res_wr_en   (res_wr_en),
      .res_wr_addr (res_wr_addr),
      .res_wr_data (res_wr_data),
      .res_rd_addr (res_rd_addr),
      .res_rd_data (res_rd_data)
   );

   // host and sequencer never write the source frame in the same cycle
   a_src_wr_excl: assert property (@(posedge clock) disable iff (reset)
      host_wr |-> !scan_src_wr_en)
      else $error("source write collision");

   // a pixel write answers on the next cycle with done set
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == OP_WRITE) |=> (rsp_valid_ff && rsp_done_ff))
      else $error("write response missing");

   // a pixel read answers with done set after its beat has passed the read state
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == OP_READ) |=> ##1 (rsp_valid_ff && rsp_done_ff))
      else $error("read response missing");

   // run completion only arrives while a run is outstanding
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> state_ff == T_RUN)
      else $error("unexpected run completion");

endmodule

FILE: rtl/bd3_ram.sv
// ----------------------------------------------------------------------------
// bd3_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bd3_ram #(
   parameter int WIDTH = bd3_pkg::PIX_W,
   parameter int DEPTH = bd3_pkg::DEF_MAX_WIDTH * bd3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bd3_scan.sv
// ----------------------------------------------------------------------------
// bd3_scan: dilation pass sequencer
// Walks the frame pixel by pixel, fetching the 3x3 window one tap per cycle
// through the single source read port and one shared compare, writes each
// new pixel to the result memory, then copies the result back to the source.
// ----------------------------------------------------------------------------
module bd3_scan #(
   parameter int MAX_WIDTH  = bd3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bd3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bd3_pkg::scan_ctrl_type                 ctrl,
   output bd3_pkg::scan_stat_type                 stat,
   // source memory
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] src_rd_addr,
   input  logic [bd3_pkg::PIX_W-1:0]               src_rd_data,
   output logic                                   src_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] src_wr_addr,
   output logic [bd3_pkg::PIX_W-1:0]               src_wr_data,
   // result memory
   output logic                                   res_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] res_wr_addr,
   output logic [bd3_pkg::PIX_W-1:0]               res_wr_data,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] res_rd_addr,
   input  logic [bd3_pkg::PIX_W-1:0]               res_rd_data
);

   import bd3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WIN   = 2'd1;
   localparam logic [1:0] S_COPY  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]        state_ff,   state_in;
   logic [PASS_W-1:0] pass_ff,    pass_in;
   logic [DIM_W-1:0]  row_ff,     row_in;
   logic [DIM_W-1:0]  col_ff,     col_in;
   logic [AW-1:0]     base_ff,    base_in;
   logic [STEP_W-1:0] step_ff,    step_in;
   logic [PIX_W-1:0]  center_ff,  center_in;
   logic              hit_ff,     hit_in;
   logic              prev_ok_ff, prev_ok_in;
   logic              cp_valid_ff, cp_valid_in;
   logic [AW-1:0]     cp_addr_ff, cp_addr_in;
   logic              done_ff,    done_in;

   logic [DIM_W-1:0]  width;
   logic [DIM_W-1:0]  height;
   logic [PIX_W-1:0]  grown;
   logic [PIX_W-1:0]  back;
   logic [1:0]        dx;
   logic [1:0]        dy;
   logic              x_ok;
   logic              y_ok;
   logic              issue_ok;
   logic              tap_hit;
   logic              last_col;
   logic              last_row;
   logic [AW-1:0]     px_addr;
   logic [AW-1:0]     nb_addr;

   assign width  = ctrl.cfg.width;
   assign height = ctrl.cfg.height;
   assign grown  = ctrl.cfg.grow_white ? PIX_WHITE : PIX_BLACK;
   assign back   = ctrl.cfg.grow_white ? PIX_BLACK : PIX_WHITE;

   // window tap address and in-frame check
   always_comb begin
      dx      = win_dx(step_ff);
      dy      = win_dy(step_ff);
      px_addr = base_ff + AW'(col_ff);
      nb_addr = px_addr;
      x_ok    = 1'b1;
      y_ok    = 1'b1;
      if (dx == OFS_MINUS) begin
         nb_addr = nb_addr - AW'(1);
         x_ok    = (col_ff != '0);
      end else if (dx == OFS_PLUS) begin
         nb_addr = nb_addr + AW'(1);
         x_ok    = (col_ff != width - DIM_W'(1));
      end
      if (dy == OFS_MINUS) begin
         nb_addr = nb_addr - ROW_STEP;
         y_ok    = (row_ff != '0);
      end else if (dy == OFS_PLUS) begin
         nb_addr = nb_addr + ROW_STEP;
         y_ok    = (row_ff != height - DIM_W'(1));
      end
      issue_ok = (step_ff < STEP_LAST) && x_ok && y_ok;
   end

   assign last_col = (col_ff == width - DIM_W'(1));
   assign last_row = (row_ff == height - DIM_W'(1));
   assign tap_hit  = prev_ok_ff && (src_rd_data == grown);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      step_in     = step_ff;
      center_in   = center_ff;
      hit_in      = hit_ff;
      prev_ok_in  = prev_ok_ff;
      cp_valid_in = 1'b0;
      cp_addr_in  = px_addr;
      done_in     = 1'b0;
      res_wr_en   = 1'b0;
      res_wr_data = center_ff;

      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               row_in     = '0;
               col_in     = '0;
               base_in    = '0;
               step_in    = STEP_CENTER;
               hit_in     = 1'b0;
               prev_ok_in = 1'b0;
               pass_in    = '0;
               if (ctrl.cfg.pass_count == '0 || width == '0 || height == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_WIN;
               end
            end
         end

         S_WIN: begin
            // issue the next tap, check the one fetched last cycle
            prev_ok_in = issue_ok;
            hit_in     = hit_ff | tap_hit;
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_CENTER_DATA) begin
               center_in = src_rd_data;
            end
            if (step_ff == STEP_LAST) begin
               res_wr_en = 1'b1;
               if (center_ff == back && (hit_ff || tap_hit)) begin
                  res_wr_data = grown;
               end
               step_in    = STEP_CENTER;
               hit_in     = 1'b0;
               prev_ok_in = 1'b0;
               if (last_col && last_row) begin
                  row_in   = '0;
                  col_in   = '0;
                  base_in  = '0;
                  state_in = S_COPY;
               end else if (last_col) begin
                  col_in  = '0;
                  row_in  = row_ff + DIM_W'(1);
                  base_in = base_ff + ROW_STEP;
               end else begin
                  col_in = col_ff + DIM_W'(1);
               end
            end
         end

         S_COPY: begin
            // read result here, write source in the next cycle
            cp_valid_in = 1'b1;
            if (last_col && last_row) begin
               row_in   = '0;
               col_in   = '0;
               base_in  = '0;
               state_in = S_FLUSH;
            end else if (last_col) begin
               col_in  = '0;
               row_in  = row_ff + DIM_W'(1);
               base_in = base_ff + ROW_STEP;
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
         end

         S_FLUSH: begin
            if (pass_ff == ctrl.cfg.pass_count - PASS_W'(1)) begin
               pass_in  = '0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               pass_in  = pass_ff + PASS_W'(1);
               step_in  = STEP_CENTER;
               state_in = S_WIN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pass_ff     <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         step_ff     <= STEP_CENTER;
         hit_ff      <= 1'b0;
         prev_ok_ff  <= 1'b0;
         cp_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         base_ff     <= base_in;
         step_ff     <= step_in;
         hit_ff      <= hit_in;
         prev_ok_ff  <= prev_ok_in;
         cp_valid_ff <= cp_valid_in;
         done_ff     <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      center_ff  <= center_in;
      cp_addr_ff <= cp_addr_in;
   end

   // memory ports
   assign src_rd_addr = nb_addr;
   assign src_wr_en   = cp_valid_ff;
   assign src_wr_addr = cp_addr_ff;
   assign src_wr_data = res_rd_data;
   assign res_wr_addr = px_addr;
   assign res_rd_addr = px_addr;

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = done_ff;

   // a run is started only while the sequencer is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == S_IDLE)
      else $error("scan started while busy");

   // copy-back writes only trail a copy read
   a_copy_window: assert property (@(posedge clock) disable iff (reset)
      cp_valid_ff |-> (state_ff == S_COPY || state_ff == S_FLUSH))
      else $error("source written outside copy phase");

   // completion is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

   // window walk stays inside the frame in use
   a_win_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WIN |-> (step_ff <= STEP_LAST && row_ff < height && col_ff < width))
      else $error("window walk out of bounds");

endmodule
